>>> design/multi_level_priority_queue_defines.svh
// Assertion macros for the queue block.
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define MLPQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mlpq same-cycle check failed");

// next-cycle implication
`define MLPQ_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mlpq next-cycle check failed");

`endif

>>> design/mlpq_pkg.sv
package mlpq_pkg;

   localparam int ACTION_W = 1;
   localparam int LEVEL_W  = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

   typedef enum logic {
      FSM_IDLE,
      FSM_READ
   } state_type;

endpackage

>>> design/multi_level_priority_queue.sv
// Channel   Ports                                        Direction
// req       req_valid req_stall req_action               in  (stall out)
//           req_priority_level req_value
// rsp       rsp_valid rsp_stall rsp_status               out (stall in)
//           rsp_removed_value rsp_served_level
//
// Insert, invalid level, full queue, underflow: stays in FSM_IDLE for the next request.
// Remove with data: the store read is registered, and FSM_READ stalls requests meanwhile.
// Reset clears head, tail and count of every queue at once; the store needs no clearing.
// A response held under rsp_stall holds off further requests until it is taken.
`include "multi_level_priority_queue_defines.svh"

module multi_level_priority_queue #(
   parameter int NUM_QUEUES = 4,
   parameter int DEPTH      = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mlpq_pkg::ACTION_W-1:0]         req_action,
   input  logic [mlpq_pkg::LEVEL_W-1:0]          req_priority_level,
   input  logic signed [mlpq_pkg::VALUE_W-1:0]   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mlpq_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [mlpq_pkg::VALUE_W-1:0]   rsp_removed_value,
   output logic [mlpq_pkg::LEVEL_W-1:0]          rsp_served_level
);

   localparam int QW      = $clog2(NUM_QUEUES);
   localparam int PW      = $clog2(DEPTH);
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int ENTRIES = NUM_QUEUES * DEPTH;
   localparam int AW      = $clog2(ENTRIES);

   mlpq_pkg::state_type state_ff, state_in;

   logic [PW-1:0] head_ff  [NUM_QUEUES];
   logic [PW-1:0] head_in  [NUM_QUEUES];
   logic [PW-1:0] tail_ff  [NUM_QUEUES];
   logic [PW-1:0] tail_in  [NUM_QUEUES];
   logic [CW-1:0] count_ff [NUM_QUEUES];
   logic [CW-1:0] count_in [NUM_QUEUES];

   logic signed [mlpq_pkg::VALUE_W-1:0] store_ff [ENTRIES];
   logic signed [mlpq_pkg::VALUE_W-1:0] rd_data_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mlpq_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [mlpq_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [mlpq_pkg::LEVEL_W-1:0]        rsp_level_ff, rsp_level_in;
   logic [mlpq_pkg::LEVEL_W-1:0]        srv_level_ff, srv_level_in;

   logic                         req_accept;
   logic                         out_free;
   logic                         rsp_load;
   logic [NUM_QUEUES-1:0]        count_nz;
   logic                         any_nz;
   logic [QW-1:0]                hit_q;
   logic [mlpq_pkg::LEVEL_W-1:0] lvl_m1;
   logic [QW-1:0]                ins_q;
   logic                         lvl_ok;
   logic                         ins_full;
   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic                         mem_re;
   logic [AW-1:0]                mem_raddr;
   logic                         read_done;
   logic                         underflow_load;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   // priority encoder over non-empty flags, level 1 wins
   always_comb begin
      hit_q = '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         count_nz[i] = (count_ff[i] != '0);
      end
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         if (count_nz[i]) begin
            hit_q = QW'(i);
         end
      end
      any_nz = |count_nz;
   end

   assign lvl_m1   = req_priority_level - mlpq_pkg::LEVEL_W'(1);
   assign ins_q    = QW'(lvl_m1);
   assign lvl_ok   = req_priority_level inside {[1:NUM_QUEUES]};
   assign ins_full = lvl_ok && (count_ff[ins_q] == CW'(DEPTH));

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != mlpq_pkg::FSM_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mlpq_pkg::FSM_IDLE: begin
            if (req_accept && (req_action == mlpq_pkg::ACT_REMOVE) && any_nz) begin
               state_in = mlpq_pkg::FSM_READ;
            end
         end
         mlpq_pkg::FSM_READ: begin
            if (out_free) begin
               state_in = mlpq_pkg::FSM_IDLE;
            end
         end
         default: state_in = mlpq_pkg::FSM_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      srv_level_in  = srv_level_ff;
      mem_we        = 1'b0;
      mem_waddr     = AW'(32'(ins_q) * DEPTH + 32'(tail_ff[ins_q]));
      mem_re        = 1'b0;
      mem_raddr     = AW'(32'(hit_q) * DEPTH + 32'(head_ff[hit_q]));
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_level_in  = rsp_level_ff;
      case (state_ff)
         mlpq_pkg::FSM_IDLE: begin
            if (req_accept) begin
               if (req_action == mlpq_pkg::ACT_INSERT) begin
                  rsp_load     = 1'b1;
                  rsp_value_in = '0;
                  rsp_level_in = '0;
                  if (!lvl_ok) begin
                     rsp_status_in = mlpq_pkg::ST_INVALID;
                  end else if (ins_full) begin
                     rsp_status_in = mlpq_pkg::ST_FULL;
                  end else begin
                     rsp_status_in   = mlpq_pkg::ST_INSERTED;
                     mem_we          = 1'b1;
                     tail_in[ins_q]  = next_slot(tail_ff[ins_q]);
                     count_in[ins_q] = count_ff[ins_q] + CW'(1);
                  end
               end else if (any_nz) begin
                  mem_re          = 1'b1;
                  head_in[hit_q]  = next_slot(head_ff[hit_q]);
                  count_in[hit_q] = count_ff[hit_q] - CW'(1);
                  srv_level_in    = mlpq_pkg::LEVEL_W'(32'(hit_q) + 1);
               end else begin
                  rsp_load      = 1'b1;
                  rsp_status_in = mlpq_pkg::ST_UNDERFLOW;
                  rsp_value_in  = '0;
                  rsp_level_in  = '0;
               end
            end
         end
         mlpq_pkg::FSM_READ: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = mlpq_pkg::ST_REMOVED;
               rsp_value_in  = rd_data_ff;
               rsp_level_in  = srv_level_ff;
            end
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlpq_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      srv_level_ff  <= srv_level_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_level_ff  <= rsp_level_in;
   end

   // value store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= req_value;
      end
      if (mem_re) begin
         rd_data_ff <= store_ff[mem_raddr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_value_ff;
   assign rsp_served_level  = rsp_level_ff;

   assign read_done      = (state_ff == mlpq_pkg::FSM_READ) && out_free;
   assign underflow_load = rsp_load && (rsp_status_in == mlpq_pkg::ST_UNDERFLOW);

   `MLPQ_ASSERT_NOW(a_read_blocks_req, state_ff == mlpq_pkg::FSM_READ, req_stall)
   `MLPQ_ASSERT_NXT(a_read_delivers, read_done, rsp_valid && rsp_status == mlpq_pkg::ST_REMOVED)
   `MLPQ_ASSERT_NOW(a_underflow_empty, underflow_load, count_nz == '0)

endmodule
